@@ src/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue: the command and
// result words, status codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 9;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } stat_t;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      count;
    } res_word_t;

    // read address selection
    typedef enum logic [2:0] {
        RD_PARENT,
        RD_TOP,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    ins_begin;
        logic    cap_top;
        logic    cap_last;
        logic    cap_left;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_item;
        logic    hole_parent;
        logic    hole_child;
        logic    fin;
        stat_t   fin_status;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic hole_root;
        logic down_ok;
        logic item_gt_parent;
        logic child_gt_item;
    } sts_t;

endpackage : mhpq_pkg

`default_nettype wire

@@ src/max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue over signed 32-bit keys with insert and
// delete-max commands, one result word per command.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each command
// returns exactly one result word, shown on result for a single cycle while
// done is high; the receiver cannot stall, so it must capture the word in
// that cycle. The heap store is a single-port-read memory with registered
// read data, and that port paces each command: an insert does one read
// and one compare per level climbed, a delete-max does top and last reads,
// then left and right child reads and a compare per level descended. A
// rejected command is answered from the dispatch state without a heap
// access. busy drops in the cycle that done rises, so a new command can
// be given at once. No clearing pass is needed after reset: the contents
// of unoccupied slots are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // command side
    input  wire logic                start,
    output logic                     busy,
    input  wire mhpq_pkg::cmd_word_t cmd,
    // result side, one-cycle strobe
    output logic                     done,
    output mhpq_pkg::res_word_t      result
);

    // command and status bundles between sequencer and datapath
    mhpq_pkg::ctl_t ctl;
    mhpq_pkg::sts_t sts;

    // sequencer: dispatch, sift-up and sift-down steps, result strobe
    mhpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // heap store, count, hole pointer and result register
    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .sts    (sts),
        .result (result)
    );

endmodule : max_heap_priority_queue

`default_nettype wire

@@ src/mhpq_datapath.sv @@
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap store, element count, hole pointer, key registers, comparators and
// the result register of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_datapath #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mhpq_pkg::cmd_word_t cmd,
    input  wire mhpq_pkg::ctl_t      ctl,
    output mhpq_pkg::sts_t           sts,
    output mhpq_pkg::res_word_t      result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int KW = mhpq_pkg::KEY_W;

    logic signed [KW-1:0] mem [CAPACITY];

    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        hole_reg, hole_next;
    logic                 func_reg;
    logic signed [KW-1:0] item_reg;
    logic signed [KW-1:0] top_reg;
    logic signed [KW-1:0] left_reg;
    logic signed [KW-1:0] rd_data_reg;
    mhpq_pkg::res_word_t  res_reg;

    logic [CW:0]          down;
    logic [CW:0]          rd_slot;
    logic [CW:0]          rd_off;
    logic [AW-1:0]        rd_idx;
    logic [CW-1:0]        wr_off;
    logic [AW-1:0]        wr_idx;
    logic signed [KW-1:0] wr_data;
    logic                 right_valid;
    logic                 take_right;
    logic signed [KW-1:0] child;
    logic [CW:0]          child_slot;

    assign down        = {hole_reg, 1'b0};
    assign right_valid = down < {1'b0, count_reg};
    assign take_right  = right_valid && (left_reg < rd_data_reg);
    assign child       = take_right ? rd_data_reg : left_reg;
    assign child_slot  = take_right ? down + (CW+1)'(1) : down;

    always_comb
    begin
        case (ctl.rd_sel)
            mhpq_pkg::RD_PARENT: rd_slot = {1'b0, hole_reg >> 1};
            mhpq_pkg::RD_TOP:    rd_slot = (CW+1)'(1);
            mhpq_pkg::RD_LAST:   rd_slot = {1'b0, count_reg};
            mhpq_pkg::RD_LEFT:   rd_slot = down;
            mhpq_pkg::RD_RIGHT:  rd_slot = down + (CW+1)'(1);
            default:             rd_slot = (CW+1)'(1);
        endcase
    end

    // slot numbers run from one, memory rows from zero
    assign rd_off = rd_slot - (CW+1)'(1);
    assign rd_idx = rd_off[AW-1:0];
    assign wr_off = hole_reg - CW'(1);
    assign wr_idx = wr_off[AW-1:0];

    // moving entry: parent on insert, larger child on delete
    assign wr_data = ctl.wr_item ? item_reg :
                     (func_reg == mhpq_pkg::FUNC_DELETE) ? child : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_comb
    begin
        count_next = count_reg;
        hole_next  = hole_reg;
        if (ctl.ins_begin)
        begin
            count_next = count_reg + CW'(1);
            hole_next  = count_reg + CW'(1);
        end
        if (ctl.cap_last)
        begin
            count_next = count_reg - CW'(1);
            hole_next  = CW'(1);
        end
        if (ctl.hole_parent)
        begin
            hole_next = hole_reg >> 1;
        end
        if (ctl.hole_child)
        begin
            hole_next = child_slot[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hole_reg  <= CW'(1);
        end
        else
        begin
            count_reg <= count_next;
            hole_reg  <= hole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg <= cmd.func;
            item_reg <= cmd.key;
        end
        if (ctl.cap_top)
        begin
            top_reg <= rd_data_reg;
        end
        if (ctl.cap_last)
        begin
            item_reg <= rd_data_reg;
        end
        if (ctl.cap_left)
        begin
            left_reg <= rd_data_reg;
        end
        if (ctl.fin)
        begin
            res_reg.out_key <= (ctl.fin_status == mhpq_pkg::STAT_DONE &&
                                func_reg == mhpq_pkg::FUNC_DELETE) ? top_reg : '0;
            res_reg.status  <= ctl.fin_status;
            res_reg.count   <= mhpq_pkg::COUNT_W'(count_reg);
        end
    end

    assign sts.is_insert      = (func_reg == mhpq_pkg::FUNC_INSERT);
    assign sts.full           = (count_reg == CW'(CAPACITY));
    assign sts.empty          = (count_reg == '0);
    assign sts.hole_root      = (hole_reg == CW'(1));
    assign sts.down_ok        = (down <= {1'b0, count_reg});
    assign sts.item_gt_parent = (item_reg > rd_data_reg);
    assign sts.child_gt_item  = (child > item_reg);

    assign result = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_begin |=> count_reg == CW'($past(count_reg) + CW'(1)))
        else $error("insert did not grow the count by one");

    // deleting the only key writes it back to the root of an empty heap
    a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (hole_reg != '0) &&
                      ((hole_reg <= count_reg) || (hole_reg == CW'(1))))
        else $error("write outside occupied slots");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fin && ctl.fin_status == mhpq_pkg::STAT_FULL) |-> sts.full)
        else $error("insert rejected while heap not full");
`endif

endmodule : mhpq_datapath

`default_nettype wire

@@ src/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer of the max-heap priority queue: dispatch, sift-up on insert,
// sift-down on delete, and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire mhpq_pkg::sts_t sts,
    output mhpq_pkg::ctl_t      ctl,
    output logic                busy,
    output logic                done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_DEL_TOP,
        ST_DEL_LAST,
        ST_DEL_RD_L,
        ST_DEL_RD_R,
        ST_DEL_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        ctl            = '0;
        ctl.rd_sel     = mhpq_pkg::RD_TOP;
        ctl.fin_status = mhpq_pkg::STAT_DONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_insert)
                begin
                    if (sts.full)
                    begin
                        ctl.fin        = 1'b1;
                        ctl.fin_status = mhpq_pkg::STAT_FULL;
                        done_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        ctl.ins_begin = 1'b1;
                        state_next    = ST_INS_CHK;
                    end
                end
                else if (sts.empty)
                begin
                    ctl.fin        = 1'b1;
                    ctl.fin_status = mhpq_pkg::STAT_EMPTY;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ctl.rd_sel = mhpq_pkg::RD_TOP;
                    state_next = ST_DEL_TOP;
                end
            end
            ST_INS_CHK:
            begin
                ctl.rd_sel = mhpq_pkg::RD_PARENT;
                if (sts.hole_root)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_item = 1'b1;
                    ctl.fin     = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                ctl.wr_en = 1'b1;
                if (sts.item_gt_parent)
                begin
                    ctl.hole_parent = 1'b1;
                    state_next      = ST_INS_CHK;
                end
                else
                begin
                    ctl.wr_item = 1'b1;
                    ctl.fin     = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_DEL_TOP:
            begin
                ctl.cap_top = 1'b1;
                ctl.rd_sel  = mhpq_pkg::RD_LAST;
                state_next  = ST_DEL_LAST;
            end
            ST_DEL_LAST:
            begin
                ctl.cap_last = 1'b1;
                state_next   = ST_DEL_RD_L;
            end
            ST_DEL_RD_L:
            begin
                ctl.rd_sel = mhpq_pkg::RD_LEFT;
                if (!sts.down_ok)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_item = 1'b1;
                    ctl.fin     = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DEL_RD_R;
                end
            end
            ST_DEL_RD_R:
            begin
                ctl.rd_sel   = mhpq_pkg::RD_RIGHT;
                ctl.cap_left = 1'b1;
                state_next   = ST_DEL_CMP;
            end
            ST_DEL_CMP:
            begin
                ctl.wr_en = 1'b1;
                if (sts.child_gt_item)
                begin
                    ctl.hole_child = 1'b1;
                    state_next     = ST_DEL_RD_L;
                end
                else
                begin
                    ctl.wr_item = 1'b1;
                    ctl.fin     = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule : mhpq_ctrl

`default_nettype wire
